FILE: rtl/core/pnc_pkg.sv
// Shared types and constants of the periodic neighbor counter.
package pnc_pkg;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam int TAG_W   = 20;
	localparam int POS_W   = 32;
	localparam int LEN_W   = 31;
	localparam int CUT_W   = 62;
	localparam int NCNT_W  = 6;
	localparam int CFG_IDX_W = 3;

	// pipeline depth from compare issue to count update
	localparam int EVAL_DRAIN = 6;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd3;

	localparam logic [LEN_W-1:0] BOX_LEN_RST = 31'd65536;
	localparam logic [CUT_W-1:0] CUTOFF_RST  = 62'h1_0000_0000;

	typedef struct packed {
		logic [LEN_W-1:0] x;
		logic [LEN_W-1:0] y;
		logic [LEN_W-1:0] z;
	} pnc_vec_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
	} pnc_pos_t;

	typedef struct packed {
		logic load;
		logic rstart;
		logic rstep;
		logic rfin;
		logic copy;
		logic shift;
		logic compare;
		logic out_shift;
	} pnc_ctl_t;

endpackage

FILE: rtl/core/pnc_intf.sv
// Stream interfaces for particle requests and count results.
interface pnc_particle_if;
	logic                             valid;
	logic                             ready;
	logic [pnc_pkg::TAG_W-1:0]        particle_tag;
	logic signed [pnc_pkg::POS_W-1:0] pos_x;
	logic signed [pnc_pkg::POS_W-1:0] pos_y;
	logic signed [pnc_pkg::POS_W-1:0] pos_z;
	logic                             set_last;

	modport source (output valid, particle_tag, pos_x, pos_y, pos_z, set_last, input ready);
	modport sink (input valid, particle_tag, pos_x, pos_y, pos_z, set_last, output ready);
endinterface

interface pnc_result_if;
	logic                       valid;
	logic                       ready;
	logic [pnc_pkg::TAG_W-1:0]  out_tag;
	logic [pnc_pkg::NCNT_W-1:0] neighbor_count;
	logic                       out_last;

	modport source (output valid, out_tag, neighbor_count, out_last, input ready);
	modport sink (input valid, out_tag, neighbor_count, out_last, output ready);
endinterface

FILE: rtl/core/pnc_axis.sv
// One axis of a cell: bit-serial modulo reduction and minimum-image square.
module pnc_axis (
	input  logic                        clk,
	input  logic                        load_en,
	input  logic [pnc_pkg::POS_W-1:0]   load_val,
	input  pnc_pkg::pnc_ctl_t           ctl,
	input  logic [pnc_pkg::LEN_W-1:0]   len,
	input  logic [pnc_pkg::LEN_W-1:0]   mov_prev,
	output logic [pnc_pkg::LEN_W-1:0]   mov,
	output logic [2*pnc_pkg::LEN_W-1:0] sq
);
	logic                        neg_q;
	logic [pnc_pkg::POS_W-1:0]   mag_q;
	logic [pnc_pkg::LEN_W-1:0]   rem_q;
	logic [pnc_pkg::LEN_W-1:0]   mov_q;
	logic [pnc_pkg::POS_W-1:0]   trial;
	logic [pnc_pkg::POS_W-1:0]   len_ext;
	logic [pnc_pkg::LEN_W-1:0]   step_rem;
	logic [pnc_pkg::LEN_W-1:0]   fin_rem;
	logic [pnc_pkg::POS_W-1:0]   dr_s1;
	logic [pnc_pkg::LEN_W-1:0]   r_s2;
	logic [pnc_pkg::LEN_W-1:0]   m_s3;
	logic [2*pnc_pkg::LEN_W-1:0] sq_s4;
	logic [pnc_pkg::POS_W-1:0]   dr_wrap;
	logic [pnc_pkg::POS_W-1:0]   two_r;

	assign len_ext  = {1'b0, len};
	assign trial    = {rem_q, mag_q[pnc_pkg::POS_W-1]};
	assign step_rem = (trial >= len_ext) ? pnc_pkg::LEN_W'(trial - len_ext)
	                                     : trial[pnc_pkg::LEN_W-1:0];
	// negative input: fold remainder back into [0, L)
	assign fin_rem  = (neg_q && rem_q != '0) ? len - rem_q : rem_q;
	assign dr_wrap  = dr_s1 + len_ext;
	assign two_r    = {r_s2, 1'b0};

	always_ff @(posedge clk) begin
		if (load_en) begin
			neg_q <= load_val[pnc_pkg::POS_W-1];
			mag_q <= load_val[pnc_pkg::POS_W-1] ? (~load_val + 1'b1) : load_val;
		end else if (ctl.rstep) begin
			mag_q <= {mag_q[pnc_pkg::POS_W-2:0], 1'b0};
		end
		if (ctl.rstart) begin
			rem_q <= '0;
		end else if (ctl.rstep) begin
			rem_q <= step_rem;
		end else if (ctl.rfin) begin
			rem_q <= fin_rem;
		end
		if (ctl.copy) begin
			mov_q <= rem_q;
		end else if (ctl.shift) begin
			mov_q <= mov_prev;
		end
		dr_s1 <= {1'b0, rem_q} - {1'b0, mov_q};
		r_s2  <= dr_s1[pnc_pkg::POS_W-1] ? dr_wrap[pnc_pkg::LEN_W-1:0]
		                                 : dr_s1[pnc_pkg::LEN_W-1:0];
		m_s3  <= (two_r >= len_ext) ? len - r_s2 : r_s2;
		sq_s4 <= (2*pnc_pkg::LEN_W)'(m_s3) * (2*pnc_pkg::LEN_W)'(m_s3);
	end

	assign mov = mov_q;
	assign sq  = sq_s4;
endmodule

FILE: rtl/core/pnc_cell.sv
// One particle cell: resident position, rotating neighbor, counter, result shift.
module pnc_cell #(
	parameter int IDX = 0,
	parameter int NW  = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pnc_pkg::pnc_ctl_t          ctl,
	input  logic [NW-1:0]              n,
	input  logic [pnc_pkg::TAG_W-1:0]  tag_in,
	input  pnc_pkg::pnc_pos_t          pos_in,
	input  pnc_pkg::pnc_vec_t          len,
	input  logic [pnc_pkg::CUT_W-1:0]  cutoff,
	input  pnc_pkg::pnc_vec_t          mov_prev,
	input  logic                       mv_prev,
	output pnc_pkg::pnc_vec_t          mov,
	output logic                       mv,
	input  logic [pnc_pkg::TAG_W-1:0]  nxt_tag,
	input  logic [pnc_pkg::NCNT_W-1:0] nxt_count,
	output logic [pnc_pkg::TAG_W-1:0]  tag,
	output logic [pnc_pkg::NCNT_W-1:0] count
);
	logic                       load_en;
	logic                       rv;
	logic                       mv_q;
	logic                       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [pnc_pkg::CUT_W-1:0]  sqx, sqy, sqz;
	logic [pnc_pkg::CUT_W-1:0]  sxy_s5, sz_s5, sum_s6;
	logic [pnc_pkg::TAG_W-1:0]  tag_q;
	logic [pnc_pkg::NCNT_W-1:0] count_q;

	assign load_en = ctl.load && (n == NW'(IDX));
	assign rv      = (n > NW'(IDX));

	pnc_axis u_x (.clk, .load_en, .load_val(pos_in.x), .ctl, .len(len.x),
		.mov_prev(mov_prev.x), .mov(mov.x), .sq(sqx));
	pnc_axis u_y (.clk, .load_en, .load_val(pos_in.y), .ctl, .len(len.y),
		.mov_prev(mov_prev.y), .mov(mov.y), .sq(sqy));
	pnc_axis u_z (.clk, .load_en, .load_val(pos_in.z), .ctl, .len(len.z),
		.mov_prev(mov_prev.z), .mov(mov.z), .sq(sqz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ctl.copy) begin
				mv_q <= rv;
			end else if (ctl.shift) begin
				mv_q <= mv_prev;
			end
			v_s1 <= ctl.compare && rv && mv_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sxy_s5 <= sqx + sqy;
		sz_s5  <= sqz;
		sum_s6 <= sxy_s5 + sz_s5;
		if (load_en) begin
			tag_q <= tag_in;
		end else if (ctl.out_shift) begin
			tag_q <= nxt_tag;
		end
		if (ctl.copy) begin
			count_q <= '0;
		end else if (ctl.out_shift) begin
			count_q <= nxt_count;
		end else if (v_s6 && sum_s6 < cutoff) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign mv    = mv_q;
	assign tag   = tag_q;
	assign count = count_q;
endmodule

FILE: rtl/core/periodic_neighbor_count.sv
// Top level of the periodic neighbor counter: sequencer, registers, cell chain.
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+---------------------------------------------
//  particle  | in  | valid / ready  | particle_tag, pos_x, pos_y, pos_z, set_last
//  result    | out | valid / ready  | out_tag, neighbor_count, out_last
//  cfg       | in  | cfg_we         | cfg_index, cfg_wdata
//
// Particle requests are accepted while the set loads. The request marked last
// starts evaluation: bit-serial modulo reduction (one bit per cycle in every cell),
// then the finalize and seed states S_RFIN and S_COPY, then S_EVAL while neighbors
// rotate through the cell chain, then the results as the result side accepts them.
// Reset clears the sequencer and fill count and loads the configuration registers
// with their reset values; no clearing pass is needed.
// A stalled result holds the chain; particle ready stays low until the last result.
module periodic_neighbor_count #(
	parameter int MAX_PARTICLES = pnc_pkg::MAX_PARTICLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pnc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pnc_pkg::CUT_W-1:0]     cfg_wdata,
	pnc_particle_if.sink                  particle,
	pnc_result_if.source                  result
);
	localparam int NW     = $clog2(MAX_PARTICLES + 1);
	localparam int EVAL_N = MAX_PARTICLES + pnc_pkg::EVAL_DRAIN;
	localparam int SEQ_W  = ($clog2(EVAL_N) > $clog2(pnc_pkg::POS_W)) ?
	                        $clog2(EVAL_N) : $clog2(pnc_pkg::POS_W);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_RSTEP = 3'd1;
	localparam logic [2:0] S_RFIN  = 3'd2;
	localparam logic [2:0] S_COPY  = 3'd3;
	localparam logic [2:0] S_EVAL  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]                    state_q;
	logic [SEQ_W-1:0]              seq_q;
	logic [NW-1:0]                 n_q;
	logic [NW-1:0]                 out_idx_q;
	logic [pnc_pkg::LEN_W-1:0]     box_x_q, box_y_q, box_z_q;
	logic [pnc_pkg::CUT_W-1:0]     cutoff_q;
	pnc_pkg::pnc_vec_t             len_eff;
	pnc_pkg::pnc_pos_t             pos_in;
	pnc_pkg::pnc_ctl_t             ctl;
	logic                          accept;
	logic                          out_acc;
	logic                          is_last;

	pnc_pkg::pnc_vec_t             mov_w [MAX_PARTICLES];
	logic                          mv_w  [MAX_PARTICLES];
	logic [pnc_pkg::TAG_W-1:0]     tag_w [MAX_PARTICLES];
	logic [pnc_pkg::NCNT_W-1:0]    cnt_w [MAX_PARTICLES];

	// a zero box length acts as one: every difference on that axis wraps to zero
	assign len_eff.x = (box_x_q == '0) ? pnc_pkg::LEN_W'(1) : box_x_q;
	assign len_eff.y = (box_y_q == '0) ? pnc_pkg::LEN_W'(1) : box_y_q;
	assign len_eff.z = (box_z_q == '0) ? pnc_pkg::LEN_W'(1) : box_z_q;

	assign pos_in.x = particle.pos_x;
	assign pos_in.y = particle.pos_y;
	assign pos_in.z = particle.pos_z;

	assign particle.ready = (state_q == S_LOAD);
	assign accept         = particle.valid && particle.ready;
	assign result.valid   = (state_q == S_OUT);
	assign out_acc        = result.valid && result.ready;
	assign is_last        = (out_idx_q == n_q - 1'b1);

	// drive the cell chain; a request beyond a full store is dropped
	always_comb begin
		ctl           = '0;
		ctl.load      = accept && (n_q < NW'(MAX_PARTICLES));
		ctl.rstart    = accept && particle.set_last;
		ctl.rstep     = (state_q == S_RSTEP);
		ctl.rfin      = (state_q == S_RFIN);
		ctl.copy      = (state_q == S_COPY);
		// rotate MAX_PARTICLES-1 times, compare after every rotation
		ctl.shift     = (state_q == S_EVAL) && (seq_q < SEQ_W'(MAX_PARTICLES - 1));
		ctl.compare   = (state_q == S_EVAL) && (seq_q != '0) &&
		                (seq_q <= SEQ_W'(MAX_PARTICLES - 1));
		ctl.out_shift = out_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q  <= pnc_pkg::BOX_LEN_RST;
			box_y_q  <= pnc_pkg::BOX_LEN_RST;
			box_z_q  <= pnc_pkg::BOX_LEN_RST;
			cutoff_q <= pnc_pkg::CUTOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pnc_pkg::REG_BOX_X:  box_x_q  <= cfg_wdata[pnc_pkg::LEN_W-1:0];
				pnc_pkg::REG_BOX_Y:  box_y_q  <= cfg_wdata[pnc_pkg::LEN_W-1:0];
				pnc_pkg::REG_BOX_Z:  box_z_q  <= cfg_wdata[pnc_pkg::LEN_W-1:0];
				pnc_pkg::REG_CUTOFF: cutoff_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			seq_q     <= '0;
			n_q       <= '0;
			out_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (ctl.load) begin
						n_q <= n_q + 1'b1;
					end
					if (ctl.rstart) begin
						seq_q   <= '0;
						state_q <= S_RSTEP;
					end
				end
				S_RSTEP: begin
					seq_q <= seq_q + 1'b1;
					if (seq_q == SEQ_W'(pnc_pkg::POS_W - 1)) begin
						state_q <= S_RFIN;
					end
				end
				S_RFIN: begin
					state_q <= S_COPY;
				end
				S_COPY: begin
					seq_q   <= '0;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					seq_q <= seq_q + 1'b1;
					// hold until the last compare has reached the counters
					if (seq_q == SEQ_W'(EVAL_N - 1)) begin
						out_idx_q <= '0;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (is_last) begin
							n_q     <= '0;
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// ring of cells; results drain toward cell 0 in load order
	for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_cell
		logic [pnc_pkg::TAG_W-1:0]  nxt_tag;
		logic [pnc_pkg::NCNT_W-1:0] nxt_count;

		if (k == MAX_PARTICLES - 1) begin : g_end
			assign nxt_tag   = '0;
			assign nxt_count = '0;
		end else begin : g_mid
			assign nxt_tag   = tag_w[k+1];
			assign nxt_count = cnt_w[k+1];
		end

		pnc_cell #(.IDX(k), .NW(NW)) u_cell (
			.clk,
			.arst_n,
			.ctl,
			.n         (n_q),
			.tag_in    (particle.particle_tag),
			.pos_in,
			.len       (len_eff),
			.cutoff    (cutoff_q),
			.mov_prev  (mov_w[(k + MAX_PARTICLES - 1) % MAX_PARTICLES]),
			.mv_prev   (mv_w[(k + MAX_PARTICLES - 1) % MAX_PARTICLES]),
			.mov       (mov_w[k]),
			.mv        (mv_w[k]),
			.nxt_tag,
			.nxt_count,
			.tag       (tag_w[k]),
			.count     (cnt_w[k])
		);
	end

	assign result.out_tag        = tag_w[0];
	assign result.neighbor_count = cnt_w[0];
	assign result.out_last       = is_last;
endmodule

FILE: rtl/core/pnc_checker.sv
// Port-level assertions for the periodic neighbor counter, bound to the top level.
module pnc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       p_valid,
	input logic                       p_ready,
	input logic                       p_last,
	input logic                       r_valid,
	input logic                       r_ready,
	input logic                       r_last,
	input logic [pnc_pkg::TAG_W-1:0]  r_tag,
	input logic [pnc_pkg::NCNT_W-1:0] r_count
);
	a_no_load_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> !p_ready)
		else $error("particle ready while results pending");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(p_valid && p_ready && p_last) |=> !p_ready)
		else $error("ready stayed high after closing request");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && r_ready && r_last) |=> !r_valid)
		else $error("result after last of set");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && r_ready && !r_last) |=> r_valid)
		else $error("result burst broken before last");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !r_ready) |=> r_valid && $stable(r_tag) && $stable(r_count)
		&& $stable(r_last))
		else $error("stalled result changed");
endmodule

bind periodic_neighbor_count pnc_checker u_pnc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.p_valid (particle.valid),
	.p_ready (particle.ready),
	.p_last  (particle.set_last),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_last  (result.out_last),
	.r_tag   (result.out_tag),
	.r_count (result.neighbor_count)
);
